[hw/rtl/ttse_pkg.sv]
// ============================================================================
// ttse_pkg
// Shared constants, command codes and types of the text terminal screen engine
// ============================================================================
package ttse_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STEPS  = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCRL_N     = COLUMNS * (ROWS - 1);

    // derived widths
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int IDX_W  = $clog2(CELL_COUNT);
    localparam int PTR_W  = $clog2(CELL_COUNT + 1);
    localparam int STEP_W = $clog2(TAB_STEPS + 1);

    // field widths
    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int CIDX_W = 11;
    localparam int CUR_W  = 11;
    localparam int DATA_W = 16;
    localparam int COLR_W = 8;

    // request queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input modes
    localparam logic [MODE_W-1:0] MODE_CHAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd6;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [COLR_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [DATA_W-1:0] CELL_RESET  = 16'h0720;

    // classified operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_PUT   = 4'd1;
    localparam logic [OP_W-1:0] OP_NL    = 4'd2;
    localparam logic [OP_W-1:0] OP_BS    = 4'd3;
    localparam logic [OP_W-1:0] OP_TAB   = 4'd4;
    localparam logic [OP_W-1:0] OP_CR    = 4'd5;
    localparam logic [OP_W-1:0] OP_CLEAR = 4'd6;
    localparam logic [OP_W-1:0] OP_UP    = 4'd7;
    localparam logic [OP_W-1:0] OP_DOWN  = 4'd8;
    localparam logic [OP_W-1:0] OP_LEFT  = 4'd9;
    localparam logic [OP_W-1:0] OP_RIGHT = 4'd10;
    localparam logic [OP_W-1:0] OP_READ  = 4'd11;
    localparam logic [OP_W-1:0] OP_READ0 = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

    // linear cell address of a row and column
    function automatic logic [IDX_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        cell_addr = IDX_W'(IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col));
    endfunction

endpackage

[hw/rtl/ttse_if.sv]
// ============================================================================
// ttse_in_if / ttse_out_if
// Valid/ready channels carrying requests and results
// ============================================================================
interface ttse_in_if;
    logic                          valid;
    logic                          ready;
    logic [ttse_pkg::MODE_W-1:0]   mode;
    logic [ttse_pkg::CHAR_W-1:0]   char_code;
    logic [ttse_pkg::CIDX_W-1:0]   cell_index;

    modport source (output valid, output mode, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input mode, input char_code, input cell_index,
                  output ready);
endinterface

interface ttse_out_if;
    logic                          valid;
    logic                          ready;
    logic [ttse_pkg::CUR_W-1:0]    cursor_index;
    logic [ttse_pkg::DATA_W-1:0]   cell_data;

    modport source (output valid, output cursor_index, output cell_data, input ready);
    modport sink (input valid, input cursor_index, input cell_data, output ready);
endinterface

[hw/rtl/ttse_front.sv]
// ============================================================================
// ttse_front
// Accepts requests, decodes them into commands and queues them
// ============================================================================
module ttse_front
(
    input  logic             clk,
    input  logic             rst_n,
    ttse_in_if.sink          in,
    input  logic             init_busy,
    input  logic             q_pop,
    output logic             q_valid,
    output ttse_pkg::cmd_t   q_cmd
);

    ttse_pkg::cmd_t                 q_mem [ttse_pkg::QDEPTH];
    logic [ttse_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ttse_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ttse_pkg::QCNT_W-1:0]    cnt_reg;
    logic                           push;
    ttse_pkg::cmd_t                 dec_cmd;

    // no requests during the power-up clearing pass
    assign in.ready = (cnt_reg != ttse_pkg::QCNT_W'(ttse_pkg::QDEPTH)) && !init_busy;
    assign push     = in.valid && in.ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = q_mem[rd_ptr_reg];

    // decode mode and character into a command
    always_comb
    begin
        dec_cmd.ch  = in.char_code;
        dec_cmd.idx = ttse_pkg::IDX_W'(in.cell_index);
        case (in.mode)
            ttse_pkg::MODE_CHAR:
            begin
                case (in.char_code)
                    ttse_pkg::CH_NEWLINE:   dec_cmd.op = ttse_pkg::OP_NL;
                    ttse_pkg::CH_BACKSPACE: dec_cmd.op = ttse_pkg::OP_BS;
                    ttse_pkg::CH_TAB:       dec_cmd.op = ttse_pkg::OP_TAB;
                    ttse_pkg::CH_RETURN:    dec_cmd.op = ttse_pkg::OP_CR;
                    default:                dec_cmd.op = ttse_pkg::OP_PUT;
                endcase
            end
            ttse_pkg::MODE_CLEAR: dec_cmd.op = ttse_pkg::OP_CLEAR;
            ttse_pkg::MODE_UP:    dec_cmd.op = ttse_pkg::OP_UP;
            ttse_pkg::MODE_DOWN:  dec_cmd.op = ttse_pkg::OP_DOWN;
            ttse_pkg::MODE_LEFT:  dec_cmd.op = ttse_pkg::OP_LEFT;
            ttse_pkg::MODE_RIGHT: dec_cmd.op = ttse_pkg::OP_RIGHT;
            ttse_pkg::MODE_READ:
            begin
                if (32'(in.cell_index) < ttse_pkg::CELL_COUNT)
                begin
                    dec_cmd.op = ttse_pkg::OP_READ;
                end
                else
                begin
                    dec_cmd.op = ttse_pkg::OP_READ0;
                end
            end
            default: dec_cmd.op = ttse_pkg::OP_NOP;
        endcase
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ttse_back.sv]
// ============================================================================
// ttse_back
// Executes commands on the cell store and cursor, drives the result register
// ============================================================================
module ttse_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ttse_pkg::COLR_W-1:0]    cfg_wdata,
    input  logic                           q_valid,
    input  ttse_pkg::cmd_t                 q_cmd,
    output logic                           q_pop,
    output logic                           init_busy,
    ttse_out_if.source                     out
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_SCRL = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_PWR  = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;

    logic [ttse_pkg::DATA_W-1:0]  mem [ttse_pkg::CELL_COUNT];
    logic [ttse_pkg::DATA_W-1:0]  rd_data_reg;
    logic [ttse_pkg::IDX_W-1:0]   rd_addr;
    logic                         we;
    logic [ttse_pkg::IDX_W-1:0]   wa;
    logic [ttse_pkg::DATA_W-1:0]  wd;

    logic [2:0]                   state_reg, state_next;
    logic [ttse_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [ttse_pkg::COL_W-1:0]   col_reg, col_next;
    logic [ttse_pkg::STEP_W-1:0]  steps_reg, steps_next;
    logic                         bs_reg, bs_next;
    logic                         dir_reg, dir_next;
    logic [ttse_pkg::PTR_W-1:0]   ptr_reg, ptr_next;
    logic [ttse_pkg::PTR_W-1:0]   fend_reg, fend_next;
    logic                         wpend_reg, wpend_next;
    logic [ttse_pkg::IDX_W-1:0]   waddr_reg, waddr_next;
    logic [ttse_pkg::COLR_W-1:0]  color_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [ttse_pkg::CUR_W-1:0]   out_cur_reg, out_cur_next;
    logic [ttse_pkg::DATA_W-1:0]  out_data_reg, out_data_next;

    logic                         finish;
    logic [ttse_pkg::DATA_W-1:0]  fin_data;
    logic                         start;
    logic [ttse_pkg::ROW_W-1:0]   rs_row, ls_row;
    logic [ttse_pkg::COL_W-1:0]   rs_col, ls_col;
    logic                         rs_scroll, ls_scroll;
    logic                         at_top, at_bottom;
    logic [ttse_pkg::IDX_W-1:0]   cur_addr;
    logic [ttse_pkg::DATA_W-1:0]  blank;

    assign init_busy = (state_reg == S_INIT);
    assign start     = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || out.ready);
    assign q_pop     = start;
    assign at_top    = (row_reg == '0);
    assign at_bottom = (row_reg == ttse_pkg::ROW_W'(ttse_pkg::ROWS - 1));
    assign cur_addr  = ttse_pkg::cell_addr(row_reg, col_reg);
    assign blank     = {color_reg, ttse_pkg::CH_SPACE};

    assign out.valid        = out_valid_reg;
    assign out.cursor_index = out_cur_reg;
    assign out.cell_data    = out_data_reg;

    // right and left cursor steps
    always_comb
    begin
        rs_row    = row_reg;
        rs_col    = col_reg + 1'b1;
        rs_scroll = 1'b0;
        if (col_reg == ttse_pkg::COL_W'(ttse_pkg::COLUMNS - 1))
        begin
            rs_col = '0;
            if (at_bottom)
            begin
                rs_scroll = 1'b1;
            end
            else
            begin
                rs_row = row_reg + 1'b1;
            end
        end
        ls_row    = row_reg;
        ls_col    = col_reg - 1'b1;
        ls_scroll = 1'b0;
        if (col_reg == '0)
        begin
            ls_col = ttse_pkg::COL_W'(ttse_pkg::COLUMNS - 1);
            if (at_top)
            begin
                ls_scroll = 1'b1;
            end
            else
            begin
                ls_row = row_reg - 1'b1;
            end
        end
    end

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        steps_next = steps_reg;
        bs_next    = bs_reg;
        dir_next   = dir_reg;
        ptr_next   = ptr_reg;
        fend_next  = fend_reg;
        wpend_next = wpend_reg;
        waddr_next = waddr_reg;
        we         = 1'b0;
        wa         = cur_addr;
        wd         = blank;
        rd_addr    = q_cmd.idx;
        finish     = 1'b0;
        fin_data   = '0;
        case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                wa       = ttse_pkg::IDX_W'(ptr_reg);
                wd       = ttse_pkg::CELL_RESET;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ttse_pkg::PTR_W'(ttse_pkg::CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (q_cmd.op)
                        ttse_pkg::OP_PUT, ttse_pkg::OP_RIGHT:
                        begin
                            if (q_cmd.op == ttse_pkg::OP_PUT)
                            begin
                                we = 1'b1;
                                wd = {color_reg, q_cmd.ch};
                            end
                            row_next = rs_row;
                            col_next = rs_col;
                            if (rs_scroll)
                            begin
                                dir_next   = 1'b0;
                                ptr_next   = '0;
                                wpend_next = 1'b0;
                                state_next = S_SCRL;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        ttse_pkg::OP_NL, ttse_pkg::OP_DOWN:
                        begin
                            if (q_cmd.op == ttse_pkg::OP_NL)
                            begin
                                col_next = '0;
                            end
                            if (at_bottom)
                            begin
                                dir_next   = 1'b0;
                                ptr_next   = '0;
                                wpend_next = 1'b0;
                                state_next = S_SCRL;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                finish   = 1'b1;
                            end
                        end
                        ttse_pkg::OP_BS, ttse_pkg::OP_LEFT:
                        begin
                            row_next = ls_row;
                            col_next = ls_col;
                            bs_next  = (q_cmd.op == ttse_pkg::OP_BS);
                            if (ls_scroll)
                            begin
                                dir_next   = 1'b1;
                                ptr_next   = '0;
                                wpend_next = 1'b0;
                                state_next = S_SCRL;
                            end
                            else if (q_cmd.op == ttse_pkg::OP_BS)
                            begin
                                state_next = S_PWR;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        ttse_pkg::OP_UP:
                        begin
                            if (at_top)
                            begin
                                dir_next   = 1'b1;
                                ptr_next   = '0;
                                wpend_next = 1'b0;
                                state_next = S_SCRL;
                            end
                            else
                            begin
                                row_next = row_reg - 1'b1;
                                finish   = 1'b1;
                            end
                        end
                        ttse_pkg::OP_TAB:
                        begin
                            steps_next = ttse_pkg::STEP_W'(ttse_pkg::TAB_STEPS);
                            state_next = S_STEP;
                        end
                        ttse_pkg::OP_CR:
                        begin
                            col_next = '0;
                            finish   = 1'b1;
                        end
                        ttse_pkg::OP_CLEAR:
                        begin
                            ptr_next   = '0;
                            fend_next  = ttse_pkg::PTR_W'(ttse_pkg::CELL_COUNT);
                            state_next = S_FILL;
                        end
                        ttse_pkg::OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                row_next   = rs_row;
                col_next   = rs_col;
                steps_next = steps_reg - 1'b1;
                if (rs_scroll)
                begin
                    dir_next   = 1'b0;
                    ptr_next   = '0;
                    wpend_next = 1'b0;
                    state_next = S_SCRL;
                end
                else if (steps_reg == ttse_pkg::STEP_W'(1))
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCRL:
            begin
                // read one row ahead, write the previous read back shifted
                if (wpend_reg)
                begin
                    we = 1'b1;
                    wa = waddr_reg;
                    wd = rd_data_reg;
                end
                if (ptr_reg != ttse_pkg::PTR_W'(ttse_pkg::SCRL_N))
                begin
                    if (dir_reg)
                    begin
                        rd_addr    = ttse_pkg::IDX_W'(ttse_pkg::SCRL_N - 1)
                                     - ttse_pkg::IDX_W'(ptr_reg);
                        waddr_next = ttse_pkg::IDX_W'(ttse_pkg::CELL_COUNT - 1)
                                     - ttse_pkg::IDX_W'(ptr_reg);
                    end
                    else
                    begin
                        rd_addr    = ttse_pkg::IDX_W'(ptr_reg)
                                     + ttse_pkg::IDX_W'(ttse_pkg::COLUMNS);
                        waddr_next = ttse_pkg::IDX_W'(ptr_reg);
                    end
                    wpend_next = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_FILL;
                    if (dir_reg)
                    begin
                        ptr_next  = '0;
                        fend_next = ttse_pkg::PTR_W'(ttse_pkg::COLUMNS);
                    end
                    else
                    begin
                        ptr_next  = ttse_pkg::PTR_W'(ttse_pkg::SCRL_N);
                        fend_next = ttse_pkg::PTR_W'(ttse_pkg::CELL_COUNT);
                    end
                end
            end
            S_FILL:
            begin
                we       = 1'b1;
                wa       = ttse_pkg::IDX_W'(ptr_reg);
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == fend_reg - 1'b1)
                begin
                    if (steps_reg != '0)
                    begin
                        state_next = S_STEP;
                    end
                    else if (bs_reg)
                    begin
                        state_next = S_PWR;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PWR:
            begin
                we         = 1'b1;
                bs_next    = 1'b0;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                fin_data   = rd_data_reg;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out.ready;
        out_cur_next   = out_cur_reg;
        out_data_next  = out_data_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_cur_next   = ttse_pkg::CUR_W'(ttse_pkg::cell_addr(row_next, col_next));
            out_data_next  = fin_data;
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_cur_reg  <= out_cur_next;
        out_data_reg <= out_data_next;
        waddr_reg    <= waddr_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            steps_reg     <= '0;
            bs_reg        <= 1'b0;
            dir_reg       <= 1'b0;
            ptr_reg       <= '0;
            fend_reg      <= '0;
            wpend_reg     <= 1'b0;
            color_reg     <= ttse_pkg::COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            steps_reg     <= steps_next;
            bs_reg        <= bs_next;
            dir_reg       <= dir_next;
            ptr_reg       <= ptr_next;
            fend_reg      <= fend_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    // checks
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ttse_pkg::ROW_W'(ttse_pkg::ROWS - 1))
        else $error("cursor row out of range");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || out.ready || state_reg != S_IDLE))
        else $error("result overwrites pending result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && q_valid))
        else $error("command taken outside idle");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("cell read did not deliver a result");

endmodule

[hw/rtl/text_terminal_screen_engine.sv]
// ============================================================================
// text_terminal_screen_engine
// Text-mode terminal: cell store, cursor, control characters and scrolling
// ============================================================================
// results: printing, moves, carriage return, newline and unused modes finish
//   from idle unless scrolling; reads via S_READ, backspace S_PWR, tab S_STEP
// scroll copies one cell per cycle over the store's one write port in S_SCRL,
//   then blanks the freed row in S_FILL; clear blanks every cell in S_FILL
// throughput: one request per cycle into a 2-deep queue while it has room, and
//   one command at a time; reset: blanking pass, no requests taken meanwhile
module text_terminal_screen_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    ttse_in_if.sink                      in,
    ttse_out_if.source                   out,
    input  logic                         cfg_we,
    input  logic [ttse_pkg::COLR_W-1:0]  cfg_wdata
);

    logic             q_valid;
    logic             q_pop;
    logic             init_busy;
    ttse_pkg::cmd_t   q_cmd;

    // request decode and queue
    ttse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .init_busy (init_busy),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd)
    );

    // command execution
    ttse_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out       (out)
    );

endmodule

[tb/ttse_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// ttse_checker
// Watches the request, result and color channels of the screen engine, keeps
// its own copy of the screen, cursor and color, and compares every result
// with the oldest prediction in order
// ============================================================================
module ttse_checker
    import ttse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ttse_in_if                req_ch,
    ttse_out_if               rsp_ch,
    input  logic              cfg_we,
    input  logic [COLR_W-1:0] cfg_wdata,
    output int                fails,
    output int                pending,
    output int                results
);

    typedef struct packed {
        logic [CUR_W-1:0]  cursor;
        logic [DATA_W-1:0] data;
    } screen_result_t;

    logic [DATA_W-1:0] screen_copy [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [COLR_W-1:0] color;
    screen_result_t    expected_results [$];
    int                mismatches;

    function automatic logic [DATA_W-1:0] blank();
        return {color, CH_SPACE};
    endfunction

    // rows move up one, bottom row blanked
    task automatic scroll_up();
        for (int i = 0; i < SCRL_N; i++)
            screen_copy[i] = screen_copy[i + COLUMNS];
        for (int i = SCRL_N; i < CELL_COUNT; i++)
            screen_copy[i] = blank();
    endtask

    // rows move down one first, then the top row is blanked
    task automatic scroll_down();
        for (int i = CELL_COUNT - 1; i >= COLUMNS; i--)
            screen_copy[i] = screen_copy[i - COLUMNS];
        for (int i = 0; i < COLUMNS; i++)
            screen_copy[i] = blank();
    endtask

    task automatic move_right();
        if (cur_col >= COLUMNS - 1)
        begin
            if (cur_row >= ROWS - 1)
                scroll_up();
            else
                cur_row++;
            cur_col = 0;
        end
        else
            cur_col++;
    endtask

    task automatic move_left();
        if (cur_col == 0)
        begin
            if (cur_row > 0)
                cur_row--;
            else
                scroll_down();
            cur_col = COLUMNS - 1;
        end
        else
            cur_col--;
    endtask

    task automatic move_down();
        if (cur_row >= ROWS - 1)
            scroll_up();
        else
            cur_row++;
    endtask

    // next screen state and result of one request
    task automatic predict_screen(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                                  input logic [CIDX_W-1:0] idx, output screen_result_t r);
        logic [DATA_W-1:0] rd;
        rd = '0;
        case (m)
            MODE_CHAR:
            begin
                if (c == CH_NEWLINE)
                begin
                    move_down();
                    cur_col = 0;
                end
                else if (c == CH_BACKSPACE)
                begin
                    move_left();
                    screen_copy[cur_row * COLUMNS + cur_col] = blank();
                end
                else if (c == CH_TAB)
                begin
                    for (int i = 0; i < TAB_STEPS; i++)
                        move_right();
                end
                else if (c == CH_RETURN)
                    cur_col = 0;
                else
                begin
                    screen_copy[cur_row * COLUMNS + cur_col] = {color, c};
                    move_right();
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_copy[i] = blank();
            end
            MODE_UP:
            begin
                if (cur_row == 0)
                    scroll_down();
                else
                    cur_row--;
            end
            MODE_DOWN:  move_down();
            MODE_LEFT:  move_left();
            MODE_RIGHT: move_right();
            MODE_READ:
            begin
                if (idx < CELL_COUNT)
                    rd = screen_copy[idx];
            end
            default: ;
        endcase
        r.cursor = CUR_W'(cur_row * COLUMNS + cur_col);
        r.data   = rd;
    endtask

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        screen_result_t exp_r;
        screen_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_copy[i] = CELL_RESET;
            cur_row = 0;
            cur_col = 0;
            color = COLOR_RESET;
            expected_results.delete();
            fails = 0;
            mismatches = 0;
            results = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.cursor = rsp_ch.cursor_index;
                got.data   = rsp_ch.cell_data;
                results++;
                if (expected_results.size() == 0)
                begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result cursor=%0d data=%h",
                                 $realtime, got.cursor, got.data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        fails++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch cursor exp=%0d got=%0d data exp=%h got=%h",
                                     $realtime, exp_r.cursor, got.cursor, exp_r.data,
                                     got.data);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                predict_screen(req_ch.mode, req_ch.char_code, req_ch.cell_index, exp_r);
                expected_results.push_back(exp_r);
            end
            if (cfg_we)
                color = cfg_wdata;
            pending = expected_results.size();
        end
    end

endmodule

[tb/tb_text_terminal_screen_engine.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_text_terminal_screen_engine
// Drives directed and random terminal requests under varying back-pressure and
// text colors; the checker beside the engine predicts and compares results
// ============================================================================
module tb_text_terminal_screen_engine;
    import ttse_pkg::*;

    localparam int CYCLE_LIMIT  = 20000000;
    localparam int RANDOM_ITEMS = 1700;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [COLR_W-1:0] cfg_wdata;
    int                fails;
    int                pending;
    int                results;
    int                sent;
    int                cycles;
    int                send_idle;
    int                recv_idle;

    ttse_in_if  req_ch ();
    ttse_out_if rsp_ch ();

    text_terminal_screen_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (req_ch),
        .out       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ttse_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fails     (fails),
        .pending   (pending),
        .results   (results)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side back-pressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    // one request, held until accepted
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                                input logic [CIDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.char_code  <= c;
        req_ch.cell_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // drain, then write the color while idle
    task automatic write_text_color(input logic [COLR_W-1:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random request mix, mostly printing with moves, reads and rare clears
    task automatic random_request();
        int                r;
        logic [MODE_W-1:0] m;
        logic [CHAR_W-1:0] c;
        logic [CIDX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        c   = CHAR_W'($urandom_range(0, 255));
        idx = ($urandom_range(0, 9) == 0) ? CIDX_W'($urandom_range(1990, 2047))
                                          : CIDX_W'($urandom_range(0, CELL_COUNT - 1));
        if (r < 55)
            m = MODE_CHAR;
        else if (r < 65)
        begin
            m = MODE_CHAR;
            case ($urandom_range(0, 3))
                0: c = CH_NEWLINE;
                1: c = CH_BACKSPACE;
                2: c = CH_TAB;
                default: c = CH_RETURN;
            endcase
        end
        else if (r < 80)
            m = MODE_READ;
        else if (r < 98)
            m = MODE_W'($urandom_range(MODE_UP, MODE_RIGHT));
        else
            m = MODE_CLEAR;
        send_request(m, c, idx);
    endtask

    task automatic random_phase(input int n, input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < n; i++)
            random_request();
    endtask

    // stimulus and verdict
    initial
    begin
        cycles    = 0;
        sent      = 0;
        send_idle = 23;
        recv_idle = 85;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_CHAR;
        req_ch.char_code  <= '0;
        req_ch.cell_index <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads of reset cells, edges of the index range
        send_request(MODE_READ, 8'h00, 11'd0);
        send_request(MODE_READ, 8'hFF, 11'd1999);
        send_request(MODE_READ, 8'h00, 11'd2000);
        send_request(MODE_READ, 8'h00, 11'd2047);
        // printing extremes and control characters
        send_request(MODE_CHAR, 8'h00, 11'd0);
        send_request(MODE_CHAR, 8'hFF, 11'd0);
        send_request(MODE_CHAR, CH_TAB, 11'd0);
        send_request(MODE_CHAR, CH_BACKSPACE, 11'd0);
        send_request(MODE_CHAR, CH_RETURN, 11'd0);
        send_request(MODE_READ, 8'h00, 11'd1);
        // up at the top row and left at cell zero both scroll down
        send_request(MODE_UP, 8'h00, 11'd0);
        send_request(MODE_LEFT, 8'h00, 11'd0);
        send_request(MODE_READ, 8'h00, 11'd80);
        send_request(MODE_RIGHT, 8'h00, 11'd0);
        send_request(MODE_CHAR, CH_NEWLINE, 11'd0);
        // walk to the bottom row, then down and newline scroll up
        for (int i = 0; i < ROWS - 2; i++)
            send_request(MODE_DOWN, 8'h00, 11'd0);
        send_request(MODE_DOWN, 8'h00, 11'd0);
        send_request(MODE_CHAR, CH_NEWLINE, 11'd0);
        // printing at the last cell wraps and scrolls
        send_request(MODE_LEFT, 8'h00, 11'd0);
        send_request(MODE_DOWN, 8'h00, 11'd0);
        send_request(MODE_CHAR, 8'h41, 11'd0);
        send_request(MODE_READ, 8'h00, 11'd1919);
        send_request(MODE_CLEAR, 8'h00, 11'd0);
        send_request(MODE_READ, 8'h00, 11'd1999);

        write_text_color(8'hFF);
        random_phase(RANDOM_ITEMS / 3, 23, 85);
        write_text_color(8'h00);
        random_phase(RANDOM_ITEMS / 3, 85, 23);
        write_text_color(COLR_W'($urandom_range(0, 255)));
        random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("requests sent %0d, results checked %0d, %0d failures", sent, results, fails);
        $display("covered printing, control codes, moves, scrolls, clears, reads, four colors");
        if (fails == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
